[src/column_insert_delete_splice_core_assert.svh]
// Assertion macros for the column splice core.
`ifndef COLUMN_INSERT_DELETE_SPLICE_CORE_ASSERT_SVH
`define COLUMN_INSERT_DELETE_SPLICE_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define CSP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("csp assertion failed");

// same-cycle implication
`define CSP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csp assertion failed");

// next-cycle implication
`define CSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csp assertion failed");

`endif

[src/csp_pkg.sv]
// Shared types and constants of the column splice core.
`default_nettype none
package csp_pkg;

    localparam logic [1:0] FILL_STRING = 2'd0;
    localparam logic [1:0] FILL_BITS   = 2'd1;

    localparam logic [7:0] CH_GAP = 8'd45;
    localparam logic [7:0] CH_DOT = 8'd46;

    // splice geometry derived from the registers and the record length
    typedef struct packed {
        logic        unchanged;
        logic [13:0] new_length;
        logic [12:0] pe;         // first index touched by the splice
        logic        ins_pos;    // positive shift: insert run
        logic [12:0] ins_n;
        logic [13:0] ins_end;
        logic [13:0] del_n;      // clipped delete count
        logic        tail_ins;   // insert lies past the source
        logic [12:0] pos;
        logic        dot_en;
        logic        del_en;
        logic [12:0] del_hi;
    } geom_t;

endpackage
`default_nettype wire

[src/csp_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module csp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[src/csp_geom.sv]
// Splice geometry: clipping, new length and load-time flag windows.
`default_nettype none
module csp_geom (
    input  logic [12:0]        splice_position,
    input  logic signed [13:0] shift_count,
    input  logic [12:0]        target_length,
    input  logic [1:0]         fill_mode,
    input  logic [12:0]        record_length,
    output csp_pkg::geom_t     geom
);
    import csp_pkg::*;

    logic [12:0] d;
    logic        neg;
    logic        posn;
    logic [13:0] mag;
    logic [13:0] room;
    logic [13:0] del;
    logic [14:0] del_end;
    logic        str_mode;
    logic [12:0] pe;

    always_comb begin
        d        = (target_length == 13'd0) ? record_length : target_length;
        neg      = shift_count[13];
        posn     = !neg && (shift_count != 14'sd0);
        mag      = neg ? (~shift_count + 14'sd1) : shift_count;
        room     = {1'b0, d} - {1'b0, splice_position};
        if (!neg || splice_position >= d) begin
            del = 14'd0;
        end else begin
            del = (mag > room) ? room : mag;
        end
        pe       = (splice_position < d) ? splice_position : d;
        str_mode = (fill_mode == FILL_STRING);
        del_end  = {2'b00, splice_position} + {1'b0, mag};

        geom.unchanged = (d == record_length)
                      && ((splice_position > record_length) || (!posn && del == 14'd0));
        if (geom.unchanged) begin
            geom.new_length = {1'b0, record_length};
        end else if (posn) begin
            geom.new_length = {1'b0, d} + {1'b0, shift_count[12:0]};
        end else begin
            geom.new_length = {1'b0, d} - del;
        end
        geom.pe       = pe;
        geom.ins_pos  = posn;
        geom.ins_n    = shift_count[12:0];
        geom.ins_end  = {1'b0, pe} + {1'b0, shift_count[12:0]};
        geom.del_n    = del;
        geom.tail_ins = splice_position > record_length;
        geom.pos      = splice_position;
        geom.dot_en   = str_mode && posn && (splice_position < record_length);
        geom.del_en   = str_mode && neg;
        geom.del_hi   = (del_end > {2'b00, record_length}) ? record_length : del_end[12:0];
    end

endmodule
`default_nettype wire

[src/column_insert_delete_splice_core.sv]
// Column splice core: source store, splice address mapping and result pipeline.
//
// Input channel s_*: one request per item. Kind begin starts a record (length,
// flags cleared), load writes a source element, read fetches one element of
// the spliced record. Every request yields exactly one result on m_*.
// Registers are written over the APB port (64-bit data, register i at 8*i); the
// user must write them only while no request is in flight; the core doesn't check.
// Each result passes the read stage, loaded at the accepting edge that does the
// store read, and then the output register; a begin result stays in the read
// stage until the geometry has refreshed.
// Throughput: one request per cycle. A begin request or a register write holds
// s_ready low for the following cycle while the registered splice geometry
// refreshes from the new length and registers.
// The store is one RAM with a registered read; a load within the record length
// writes it at accept, and a read accepted later sees the data.
// Reset clears the registers, the record length and both flags; store contents
// are undefined until loaded. s_ready is low in the first cycle after reset.
// When m_ready is low the output register and the read stage hold their
// requests; s_ready drops once both are full, and nothing is lost.
`default_nettype none
`include "column_insert_delete_splice_core_assert.svh"
module column_insert_delete_splice_core #(
    parameter int MAX_ELEMS = 4096,
    parameter int ELEM_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [12:0] s_elem_index,
    input  logic [31:0] s_elem_value,
    input  logic [12:0] s_source_length,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_value,
    output logic        m_in_range,
    output logic        m_unchanged,
    output logic        m_delete_refused,
    output logic [13:0] m_new_length
);
    import csp_pkg::*;

    localparam int AW = $clog2(MAX_ELEMS);

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] REG_POS      = 3'd0;
    localparam logic [2:0] REG_SHIFT    = 3'd1;
    localparam logic [2:0] REG_TARGET   = 3'd2;
    localparam logic [2:0] REG_FILL     = 3'd3;
    localparam logic [2:0] REG_FORBID_A = 3'd4;
    localparam logic [2:0] REG_FORBID_B = 3'd5;
    localparam logic [2:0] REG_FORBID_C = 3'd6;
    localparam logic [2:0] REG_FORBID_D = 3'd7;

    typedef enum logic [1:0] {SRC_ZERO, SRC_MEM, SRC_INS, SRC_TAIL} src_t;

    // configuration registers
    logic [12:0]  splice_position_reg;
    logic [13:0]  shift_count_reg;
    logic [12:0]  target_length_reg;
    logic [1:0]   fill_mode_reg;
    logic [255:0] forbid_reg;

    // record state
    logic [12:0]  record_length_reg, record_length_next;
    logic         dot_adjacent_reg, dot_adjacent_next;
    logic         refusal_reg, refusal_next;
    logic         stale_reg, stale_next;
    geom_t        geom_reg, geom_next;

    // read stage and output register
    logic         v1_reg, v1_next;
    src_t         cls1_reg, cls_next;
    logic         inr1_reg, inr_next;
    logic         m_valid_reg, m_valid_next;

    logic                 cfg_wr;
    logic                 acc;
    logic                 adv;
    logic                 is_begin, is_load, is_read;
    logic                 load_ok;
    logic [ELEM_BITS-1:0] val_m;
    logic [13:0]          idx14;
    logic [14:0]          j;
    logic                 in_seg;
    logic                 dot_hit, del_hit;
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [ELEM_BITS-1:0] ram_rdata;
    logic [ELEM_BITS-1:0] tail_val, ins_val, out_val;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[5:3])
            REG_POS:      prdata = 64'(splice_position_reg);
            REG_SHIFT:    prdata = 64'(shift_count_reg);
            REG_TARGET:   prdata = 64'(target_length_reg);
            REG_FILL:     prdata = 64'(fill_mode_reg);
            REG_FORBID_A: prdata = forbid_reg[63:0];
            REG_FORBID_B: prdata = forbid_reg[127:64];
            REG_FORBID_C: prdata = forbid_reg[191:128];
            REG_FORBID_D: prdata = forbid_reg[255:192];
            default:      prdata = 64'd0;
        endcase
    end

    csp_geom u_geom (
        .splice_position (splice_position_reg),
        .shift_count     (shift_count_reg),
        .target_length   (target_length_reg),
        .fill_mode       (fill_mode_reg),
        .record_length   (record_length_reg),
        .geom            (geom_next)
    );

    // handshake: geometry must be current before requests move
    assign adv     = v1_reg && !stale_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stale_reg && (!v1_reg || adv);
    assign acc     = s_valid && s_ready;

    assign is_begin = (s_kind == KIND_BEGIN);
    assign is_load  = (s_kind == KIND_LOAD);
    assign is_read  = (s_kind == KIND_READ);
    assign load_ok  = is_load && (s_elem_index < record_length_reg);
    assign val_m    = s_elem_value[ELEM_BITS-1:0];
    assign idx14    = {1'b0, s_elem_index};

    // output index to source index
    always_comb begin
        in_seg = !geom_reg.unchanged && (s_elem_index >= geom_reg.pe);
        if (!in_seg) begin
            j = {2'b00, s_elem_index};
        end else if (geom_reg.ins_pos) begin
            j = {2'b00, s_elem_index} - {2'b00, geom_reg.ins_n};
        end else begin
            j = {2'b00, s_elem_index} + {1'b0, geom_reg.del_n};
        end

        inr_next = is_read && (idx14 < geom_reg.new_length);
        if (!inr_next) begin
            cls_next = SRC_ZERO;
        end else if (in_seg && geom_reg.ins_pos && (idx14 < geom_reg.ins_end)) begin
            cls_next = SRC_INS;
        end else if (j < {2'b00, record_length_reg}) begin
            cls_next = SRC_MEM;
        end else begin
            cls_next = SRC_TAIL;
        end
    end

    assign ram_we    = acc && load_ok;
    assign ram_waddr = AW'(s_elem_index);
    assign ram_re    = acc && (cls_next == SRC_MEM);
    assign ram_raddr = AW'(j);

    csp_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_m),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // load-time flags
    assign dot_hit = geom_reg.dot_en
                  && ((s_elem_index == geom_reg.pos)
                      || (idx14 + 14'd1 == {1'b0, geom_reg.pos}))
                  && (val_m == ELEM_BITS'(CH_DOT));
    assign del_hit = geom_reg.del_en
                  && (s_elem_index >= geom_reg.pos)
                  && (s_elem_index < geom_reg.del_hi)
                  && forbid_reg[val_m[7:0]];

    always_comb begin
        record_length_next = record_length_reg;
        dot_adjacent_next  = dot_adjacent_reg;
        refusal_next       = refusal_reg;
        if (acc && is_begin) begin
            if (17'(s_source_length) > 17'(MAX_ELEMS)) begin
                record_length_next = 13'(MAX_ELEMS);
            end else begin
                record_length_next = s_source_length;
            end
            dot_adjacent_next = 1'b0;
            refusal_next      = 1'b0;
        end else if (acc && load_ok) begin
            dot_adjacent_next = dot_adjacent_reg || dot_hit;
            refusal_next      = refusal_reg || del_hit;
        end
        stale_next   = (acc && is_begin) || cfg_wr;
        v1_next      = acc ? 1'b1 : (adv ? 1'b0 : v1_reg);
        m_valid_next = adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // result value selection
    always_comb begin
        case (fill_mode_reg)
            FILL_STRING: tail_val = ELEM_BITS'(CH_DOT);
            FILL_BITS:   tail_val = ELEM_BITS'(CH_GAP);
            default:     tail_val = '0;
        endcase
        if (geom_reg.tail_ins) begin
            ins_val = tail_val;
        end else if (fill_mode_reg == FILL_STRING) begin
            ins_val = dot_adjacent_reg ? ELEM_BITS'(CH_DOT) : ELEM_BITS'(CH_GAP);
        end else begin
            ins_val = tail_val;
        end
        case (cls1_reg)
            SRC_MEM:  out_val = ram_rdata;
            SRC_INS:  out_val = ins_val;
            SRC_TAIL: out_val = tail_val;
            default:  out_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            splice_position_reg <= '0;
            shift_count_reg     <= '0;
            target_length_reg   <= '0;
            fill_mode_reg       <= '0;
            forbid_reg          <= '0;
            record_length_reg   <= '0;
            dot_adjacent_reg    <= 1'b0;
            refusal_reg         <= 1'b0;
            stale_reg           <= 1'b1;
            v1_reg              <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[5:3])
                    REG_POS:      splice_position_reg  <= pwdata[12:0];
                    REG_SHIFT:    shift_count_reg      <= pwdata[13:0];
                    REG_TARGET:   target_length_reg    <= pwdata[12:0];
                    REG_FILL:     fill_mode_reg        <= pwdata[1:0];
                    REG_FORBID_A: forbid_reg[63:0]     <= pwdata;
                    REG_FORBID_B: forbid_reg[127:64]   <= pwdata;
                    REG_FORBID_C: forbid_reg[191:128]  <= pwdata;
                    REG_FORBID_D: forbid_reg[255:192]  <= pwdata;
                    default: begin
                    end
                endcase
            end
            record_length_reg <= record_length_next;
            dot_adjacent_reg  <= dot_adjacent_next;
            refusal_reg       <= refusal_next;
            stale_reg         <= stale_next;
            v1_reg            <= v1_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        geom_reg <= geom_next;
        if (acc) begin
            cls1_reg <= cls_next;
            inr1_reg <= inr_next;
        end
        if (adv) begin
            m_out_value      <= 32'(out_val);
            m_in_range       <= inr1_reg;
            m_unchanged      <= geom_reg.unchanged;
            m_delete_refused <= refusal_reg;
            m_new_length     <= geom_reg.new_length;
        end
    end

    assign m_valid = m_valid_reg;

    `CSP_ASSERT_NEXT(a_begin_interlock, s_valid && s_ready && s_kind == KIND_BEGIN, !s_ready)
    `CSP_ASSERT_IMPLY(a_range_nonempty, m_valid && m_in_range, m_new_length != 14'd0)
    `CSP_ASSERT_ALWAYS(a_length_bound, 17'(record_length_reg) <= 17'(MAX_ELEMS))

endmodule
`default_nettype wire
